// ----- rtl/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// skt_pkg: shared definitions of the sorted keyframe table
// Default sizes, action and status codes, and the command and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

	localparam int KEYS_PER_TRACK_DEF = 64;
	localparam int TRACKS_DEF         = 3;

	// Action codes of an input item.
	localparam logic [1:0] ACT_INSERT    = 2'd0;
	localparam logic [1:0] ACT_FIND_NEXT = 2'd1;
	localparam logic [1:0] ACT_FIND_PREV = 2'd2;

	// Status codes of a result item.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	// Source of the fields of a result item.
	typedef enum logic [1:0] {
		RES_FAIL = 2'd0,
		RES_MEM  = 2'd1,
		RES_NEW  = 2'd2
	} res_sel_t;

	typedef struct packed {
		logic       load_in;
		logic       idx_init;
		logic       idx_inc;
		logic       idx_dec;
		logic       rd;
		logic       wr_shift;
		logic       wr_new;
		logic       out_load;
		res_sel_t   res_sel;
		logic [1:0] res_st;
	} skt_cmd_t;

	typedef struct packed {
		logic bad_req;
		logic is_insert;
		logic is_next;
		logic cnt_zero;
		logic cnt_full;
		logic idx_zero;
		logic idx_last;
		logic cmp_gt;
		logic cmp_ge;
		logic out_free;
	} skt_sts_t;

endpackage

`default_nettype wire

// ----- rtl/skt_ctrl.sv -----
// ----------------------------------------------------------------------------
// skt_ctrl: sequencer of the sorted keyframe table
// Steps one item at a time through request check, entry scan and result.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_ctrl import skt_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	input  wire skt_sts_t sts,
	output skt_cmd_t      cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CHECK = 5'b00010,
		S_LOOP  = 5'b00100,
		S_CMP   = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	state_t     state_q, state_d;
	res_sel_t   res_sel_q, res_sel_d;
	logic [1:0] res_st_q, res_st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			res_sel_q <= RES_FAIL;
			res_st_q  <= ST_OK;
		end else begin
			state_q   <= state_d;
			res_sel_q <= res_sel_d;
			res_st_q  <= res_st_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		res_sel_d    = res_sel_q;
		res_st_d     = res_st_q;
		cmd          = '0;
		cmd.res_sel  = res_sel_q;
		cmd.res_st   = res_st_q;
		s_tready     = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready    = 1'b1;
				cmd.load_in = s_tvalid;
				if (s_tvalid) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.bad_req) begin
					res_sel_d = RES_FAIL;
					res_st_d  = ST_NOT_FOUND;
					state_d   = S_OUT;
				end else if (sts.is_insert && sts.cnt_full) begin
					res_sel_d = RES_FAIL;
					res_st_d  = ST_FULL;
					state_d   = S_OUT;
				end else if (!sts.is_insert && sts.cnt_zero) begin
					res_sel_d = RES_FAIL;
					res_st_d  = ST_EMPTY;
					state_d   = S_OUT;
				end else begin
					cmd.idx_init = 1'b1;
					state_d      = S_LOOP;
				end
			end
			S_LOOP: begin
				if (sts.is_insert && sts.idx_zero) begin
					cmd.wr_new = 1'b1;
					res_sel_d  = RES_NEW;
					res_st_d   = ST_OK;
					state_d    = S_OUT;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				if (sts.is_insert) begin
					// Entries later than the new key move up one place.
					if (sts.cmp_gt) begin
						cmd.wr_shift = 1'b1;
						cmd.idx_dec  = 1'b1;
						state_d      = S_LOOP;
					end else begin
						cmd.wr_new = 1'b1;
						res_sel_d  = RES_NEW;
						res_st_d   = ST_OK;
						state_d    = S_OUT;
					end
				end else if (sts.is_next) begin
					if (sts.cmp_ge) begin
						res_sel_d = RES_MEM;
						res_st_d  = ST_OK;
						state_d   = S_OUT;
					end else if (sts.idx_last) begin
						res_sel_d = RES_FAIL;
						res_st_d  = ST_NOT_FOUND;
						state_d   = S_OUT;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = S_LOOP;
					end
				end else begin
					// Previous: scan down; the first entry is the fallback.
					if (!sts.cmp_gt || sts.idx_zero) begin
						res_sel_d = RES_MEM;
						res_st_d  = ST_OK;
						state_d   = S_OUT;
					end else begin
						cmd.idx_dec = 1'b1;
						state_d     = S_LOOP;
					end
				end
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/skt_dp.sv -----
// ----------------------------------------------------------------------------
// skt_dp: datapath of the sorted keyframe table
// Request registers, entry memory, per-track fill counts, scan index,
// time compare and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_dp import skt_pkg::*; #(
	parameter int KEYS_PER_TRACK = KEYS_PER_TRACK_DEF,
	parameter int TRACKS         = TRACKS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [159:0] s_tdata,
	input  wire logic [3:0]   s_tuser,
	input  wire skt_cmd_t     cmd,
	output skt_sts_t          sts,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [167:0]      m_tdata,
	output logic [1:0]        m_tuser
);

	localparam int IW    = $clog2(KEYS_PER_TRACK);
	localparam int CW    = $clog2(KEYS_PER_TRACK + 1);
	localparam int DEPTH = TRACKS * KEYS_PER_TRACK;
	localparam int AW    = $clog2(DEPTH);
	localparam int TW    = (TRACKS > 1) ? $clog2(TRACKS) : 1;

	logic [1:0]    act_q, trk_q;
	logic [31:0]   key_time_q;
	logic [63:0]   pay_lo_q, pay_hi_q;
	logic [CW-1:0] cnt_q [TRACKS];
	logic [IW-1:0] idx_q;

	logic [31:0] time_mem [DEPTH];
	logic [63:0] plo_mem  [DEPTH];
	logic [63:0] phi_mem  [DEPTH];
	logic [31:0] rd_time_q;
	logic [63:0] rd_lo_q, rd_hi_q;

	logic          out_valid_q;
	logic [1:0]    out_st_q;
	logic [5:0]    out_idx_q;
	logic [31:0]   out_time_q;
	logic [63:0]   out_lo_q, out_hi_q;

	logic          trk_bad, is_insert;
	logic [TW-1:0] trk_idx;
	logic [CW-1:0] cur_cnt;
	logic [IW-1:0] rd_idx;
	logic [AW-1:0] base, rd_addr, wr_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= ACT_INSERT;
			trk_q <= 2'd0;
		end else if (cmd.load_in) begin
			act_q <= s_tuser[1:0];
			trk_q <= s_tuser[3:2];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			key_time_q <= s_tdata[31:0];
			pay_lo_q   <= s_tdata[95:32];
			pay_hi_q   <= s_tdata[159:96];
		end
	end

	assign trk_bad   = ({30'd0, trk_q} >= 32'(TRACKS));
	assign trk_idx   = trk_bad ? '0 : trk_q[TW-1:0];
	assign cur_cnt   = cnt_q[trk_idx];
	assign is_insert = (act_q == ACT_INSERT);

	// Insert reads the entry below the free slot; finds read the slot itself.
	assign rd_idx  = is_insert ? (idx_q - IW'(1)) : idx_q;
	assign base    = AW'(trk_idx) * AW'(KEYS_PER_TRACK);
	assign rd_addr = base + AW'(rd_idx);
	assign wr_addr = base + AW'(idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < TRACKS; t++) begin
				cnt_q[t] <= '0;
			end
			idx_q <= '0;
		end else begin
			if (cmd.wr_new) begin
				cnt_q[trk_idx] <= cur_cnt + CW'(1);
			end
			if (cmd.idx_init) begin
				case (act_q)
					ACT_INSERT:    idx_q <= IW'(cur_cnt);
					ACT_FIND_NEXT: idx_q <= '0;
					default:       idx_q <= IW'(cur_cnt - CW'(1));
				endcase
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IW'(1);
			end else if (cmd.idx_dec) begin
				idx_q <= idx_q - IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_shift) begin
			time_mem[wr_addr] <= rd_time_q;
			plo_mem[wr_addr]  <= rd_lo_q;
			phi_mem[wr_addr]  <= rd_hi_q;
		end else if (cmd.wr_new) begin
			time_mem[wr_addr] <= key_time_q;
			plo_mem[wr_addr]  <= pay_lo_q;
			phi_mem[wr_addr]  <= pay_hi_q;
		end
		if (cmd.rd) begin
			rd_time_q <= time_mem[rd_addr];
			rd_lo_q   <= plo_mem[rd_addr];
			rd_hi_q   <= phi_mem[rd_addr];
		end
	end

	always_comb begin
		sts           = '0;
		sts.bad_req   = trk_bad || (act_q != ACT_INSERT && act_q != ACT_FIND_NEXT
			&& act_q != ACT_FIND_PREV);
		sts.is_insert = is_insert;
		sts.is_next   = (act_q == ACT_FIND_NEXT);
		sts.cnt_zero  = (cur_cnt == '0);
		sts.cnt_full  = (cur_cnt >= CW'(KEYS_PER_TRACK));
		sts.idx_zero  = (idx_q == '0);
		sts.idx_last  = (CW'(idx_q) == cur_cnt - CW'(1));
		sts.cmp_gt    = (rd_time_q > key_time_q);
		sts.cmp_ge    = (rd_time_q >= key_time_q);
		sts.out_free  = !out_valid_q || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.res_sel)
				RES_MEM: begin
					out_st_q   <= ST_OK;
					out_idx_q  <= 6'(idx_q);
					out_time_q <= rd_time_q;
					out_lo_q   <= rd_lo_q;
					out_hi_q   <= rd_hi_q;
				end
				RES_NEW: begin
					out_st_q   <= ST_OK;
					out_idx_q  <= 6'(idx_q);
					out_time_q <= key_time_q;
					out_lo_q   <= pay_lo_q;
					out_hi_q   <= pay_hi_q;
				end
				default: begin
					out_st_q   <= cmd.res_st;
					out_idx_q  <= '0;
					out_time_q <= '0;
					out_lo_q   <= '0;
					out_hi_q   <= '0;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_st_q;
	assign m_tdata  = {2'b00, out_hi_q, out_lo_q, out_time_q, out_idx_q};

endmodule

`default_nettype wire

// ----- rtl/sorted_keyframe_table.sv -----
// ----------------------------------------------------------------------------
// sorted_keyframe_table: time-ordered keyframe tracks with sorted insert
// Holds translation, rotation and scaling tracks of timed four-word keys and
// answers insert, find-next and find-previous requests.
// ----------------------------------------------------------------------------
// The block works on one item at a time and holds its entries in three
// memories (key time and two payload halves) that share one address and one
// registered read port, so an item's time is set by how many entries it
// visits: each visited entry is first read and then compared and, on insert,
// written one place up. A request that is rejected at once (unknown action
// or track, full track on insert, find on an empty track) goes from the
// check state straight to the output state. An insert scans down from the
// free slot at the end of its track and lands first when it reaches slot
// zero; a find-next scans up from the first key and reports not found after
// the last; a find-previous scans down from the last key and falls back to
// the first. The controller is back in idle on the edge that loads the
// result. A new item is taken while the previous result still waits on the
// output; only when the next result is ready and the output is still held
// does the controller wait. The entry memories need no clearing pass after
// reset: only the per-track fill counts are cleared, and entries at or above
// a track's count are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_keyframe_table import skt_pkg::*; #(
	parameter int KEYS_PER_TRACK = KEYS_PER_TRACK_DEF,
	parameter int TRACKS         = TRACKS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// key_time[31:0], word_0[63:32], word_1[95:64], word_2[127:96],
	// word_3[159:128]
	input  wire logic [159:0] s_tdata,
	// action[1:0], track[3:2]
	input  wire logic [3:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// entry_index[5:0], entry_time[37:6], out_word_0[69:38],
	// out_word_1[101:70], out_word_2[133:102], out_word_3[165:134], zero fill
	output logic [167:0]      m_tdata,
	// status[1:0]
	output logic [1:0]        m_tuser
);

	skt_cmd_t cmd;
	skt_sts_t sts;

	// The controller sequences each item; the datapath owns all storage.
	skt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	skt_dp #(
		.KEYS_PER_TRACK (KEYS_PER_TRACK),
		.TRACKS         (TRACKS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

// ----- sim/sorted_keyframe_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_keyframe_table_tb: self-checking bench for the sorted keyframe table
// Drives insert, find-next and find-previous items into the three tracks and
// predicts each result from a private copy of the sorted tracks. Runs a
// directed opening, then four random phases with different idle and stall
// patterns, one long output hold-off, and a drain between phases.
// ----------------------------------------------------------------------------

module sorted_keyframe_table_tb;
	import skt_pkg::*;

	localparam int KEYS         = KEYS_PER_TRACK_DEF;
	localparam int TRACKS       = TRACKS_DEF;
	localparam int CYCLE_LIMIT  = 3000000;
	localparam int PHASE_ITEMS  = 470;
	localparam int HOLD_CYCLES  = 600;
	localparam int SETTLE_WAIT  = 200;

	// The block defines three actions; the fourth code must be rejected.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam logic [1:0] TRK_TRANSLATION = 2'd0;
	localparam logic [1:0] TRK_ROTATION    = 2'd1;
	localparam logic [1:0] TRK_SCALING     = 2'd2;
	localparam logic [1:0] TRK_UNUSED      = 2'd3;

	typedef struct packed {
		logic [1:0]       action;
		logic [1:0]       track;
		logic [31:0]      key_time;
		logic [3:0][31:0] words;
	} request_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [5:0]       index;
		logic [31:0]      stamp;
		logic [3:0][31:0] words;
	} answer_t;

	// Holds a private copy of the three tracks and the answers still owed.
	class keyframe_scoreboard;
		logic [31:0]      key_stamp [TRACKS][KEYS];
		logic [3:0][31:0] key_words [TRACKS][KEYS];
		int unsigned      fill [TRACKS];
		answer_t          awaited [$];
		int unsigned      mismatches;
		int unsigned      answers_seen;
		int unsigned      status_seen [4];

		task report(string msg);
			$display("MISMATCH at result %0d: %s", answers_seen, msg);
			mismatches++;
		endtask

		function int unsigned outstanding();
			return awaited.size();
		endfunction

		// Query times near stored keys reach the equal and off-by-one cases.
		function logic [31:0] pick_time(logic [1:0] trk);
			int unsigned n;
			int unsigned roll;
			logic [31:0] base;
			n = (trk < TRACKS) ? fill[trk] : 0;
			roll = $urandom_range(99);
			if (roll < 40 && n != 0) begin
				base = key_stamp[trk][$urandom_range(n - 1)];
				case ($urandom_range(2))
				0: return base - 32'd1;
				1: return base;
				default: return base + 32'd1;
				endcase
			end else if (roll < 65) begin
				case ($urandom_range(3))
				0: return 32'h0;
				1: return 32'hFFFF_FFFF;
				default: return 32'($urandom_range(15)) << 16;
				endcase
			end
			return $urandom();
		endfunction

		// Applies one accepted item to the tracks and queues the result it owes.
		function void apply_request(request_t r);
			answer_t a;
			int unsigned n;
			int unsigned pos;
			int unsigned hit;
			int unsigned i;
			bit found;
			a = '0;
			if (r.track >= TRACKS || r.action == ACT_UNUSED) begin
				a.status = ST_NOT_FOUND;
			end else begin
				n = fill[r.track];
				if (r.action == ACT_INSERT) begin
					if (n >= KEYS) begin
						a.status = ST_FULL;
					end else begin
						// Land after every key at or below the new time, so
						// equal times keep their arrival order.
						pos = 0;
						for (i = 0; i < n; i++)
							if (key_stamp[r.track][i] <= r.key_time)
								pos = i + 1;
						for (i = n; i > pos; i--) begin
							key_stamp[r.track][i] = key_stamp[r.track][i - 1];
							key_words[r.track][i] = key_words[r.track][i - 1];
						end
						key_stamp[r.track][pos] = r.key_time;
						key_words[r.track][pos] = r.words;
						fill[r.track] = n + 1;
						a.status = ST_OK;
						a.index  = 6'(pos);
						a.stamp  = r.key_time;
						a.words  = r.words;
					end
				end else if (n == 0) begin
					a.status = ST_EMPTY;
				end else if (r.action == ACT_FIND_NEXT) begin
					found = 1'b0;
					for (i = 0; i < n; i++) begin
						if (!found && key_stamp[r.track][i] >= r.key_time) begin
							found    = 1'b1;
							a.status = ST_OK;
							a.index  = 6'(i);
							a.stamp  = key_stamp[r.track][i];
							a.words  = key_words[r.track][i];
						end
					end
					if (!found)
						a.status = ST_NOT_FOUND;
				end else begin
					// Last key at or before the query, else the first key.
					hit = 0;
					for (i = 0; i < n; i++)
						if (key_stamp[r.track][i] <= r.key_time)
							hit = i;
					a.status = ST_OK;
					a.index  = 6'(hit);
					a.stamp  = key_stamp[r.track][hit];
					a.words  = key_words[r.track][hit];
				end
			end
			awaited = {awaited, a};
		endfunction

		task check_answer(answer_t got);
			answer_t want;
			int k;
			answers_seen++;
			status_seen[got.status]++;
			if (awaited.size() == 0) begin
				report($sformatf("result with status %0d arrived with none pending",
					got.status));
				return;
			end
			want = awaited.pop_front();
			if (got.status !== want.status)
				report($sformatf("status got %0d, expected %0d", got.status, want.status));
			if (got.index !== want.index)
				report($sformatf("entry_index got %0d, expected %0d", got.index, want.index));
			if (got.stamp !== want.stamp)
				report($sformatf("entry_time got %h, expected %h", got.stamp, want.stamp));
			for (k = 0; k < 4; k++)
				if (got.words[k] !== want.words[k])
					report($sformatf("out_word_%0d got %h, expected %h", k,
						got.words[k], want.words[k]));
		endtask
	endclass

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic [159:0] s_tdata  = '0;
	logic [3:0]   s_tuser  = '0;
	logic         m_tready = 1'b0;
	logic         s_tready;
	logic         m_tvalid;
	logic [167:0] m_tdata;
	logic [1:0]   m_tuser;

	keyframe_scoreboard sb;
	int unsigned        cycle_count    = 0;
	int unsigned        sender_idle    = 0;
	int unsigned        receiver_stall = 0;
	int unsigned        holds_asked    = 0;
	request_t           opening_items [$];

	sorted_keyframe_table u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timeout after %0d cycles", cycle_count);
		$display("sorted_keyframe_table test failed");
		$finish;
	end

	// Output side: checks every accepted result, stalls at random, and serves
	// a long hold-off whenever the stimulus asks for one.
	initial begin
		answer_t got;
		int unsigned holds_done;
		int unsigned hold_left;
		holds_done = 0;
		hold_left  = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got.status   = m_tuser;
				got.index    = m_tdata[5:0];
				got.stamp    = m_tdata[37:6];
				got.words[0] = m_tdata[69:38];
				got.words[1] = m_tdata[101:70];
				got.words[2] = m_tdata[133:102];
				got.words[3] = m_tdata[165:134];
				sb.check_answer(got);
			end
			if (holds_done != holds_asked) begin
				holds_done = holds_asked;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= receiver_stall);
			end
		end
	end

	task automatic send_request(input request_t r);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < sender_idle)
			gap++;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= {r.words, r.key_time};
		s_tuser  <= {r.track, r.action};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.apply_request(r);
	endtask

	// Lowers the valid and waits until every owed result has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	function automatic request_t make_request(logic [1:0] act, logic [1:0] trk,
		logic [31:0] t, logic [31:0] w);
		request_t r;
		r.action   = act;
		r.track    = trk;
		r.key_time = t;
		r.words    = {w, w, w, w};
		return r;
	endfunction

	// Appends one item to the directed opening list.
	function automatic void queue_opening(request_t r);
		opening_items = {opening_items, r};
	endfunction

	// Mostly valid items on real tracks with times often drawn near stored keys;
	// a small share of noise covers unknown actions and tracks.
	function automatic request_t random_request(int unsigned insert_pct);
		request_t r;
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 8) begin
			r.action = 2'($urandom_range(3));
			r.track  = 2'($urandom_range(3));
		end else begin
			r.track = 2'($urandom_range(TRACKS - 1));
			if ($urandom_range(99) < insert_pct)
				r.action = ACT_INSERT;
			else
				r.action = $urandom_range(1) ? ACT_FIND_NEXT : ACT_FIND_PREV;
		end
		r.key_time = sb.pick_time(r.track);
		r.words    = {$urandom(), $urandom(), $urandom(), $urandom()};
		return r;
	endfunction

	initial begin
		int unsigned idle_plan [4];
		int unsigned stall_plan [4];
		int unsigned items_sent;
		int phase;
		int n;
		sb = new();
		idle_plan  = '{0, 74, 0, 11};
		stall_plan = '{0, 0, 74, 11};
		items_sent = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty tracks, rejected codes, sorted inserts with equal times, and
		// finds that hit the first, last and missing cases.
		queue_opening(make_request(ACT_FIND_NEXT, TRK_TRANSLATION, 32'h0, 32'h0));
		queue_opening(make_request(ACT_FIND_PREV, TRK_ROTATION, 32'hFFFF_FFFF, 32'h0));
		queue_opening(make_request(ACT_FIND_NEXT, TRK_SCALING, 32'h5, 32'h0));
		queue_opening(make_request(ACT_UNUSED, TRK_TRANSLATION, 32'h1, 32'h1));
		queue_opening(make_request(ACT_INSERT, TRK_UNUSED, 32'h2, 32'h2));
		queue_opening(make_request(ACT_FIND_PREV, TRK_UNUSED, 32'h3, 32'h3));
		queue_opening(make_request(ACT_INSERT, TRK_TRANSLATION, 32'h0001_8000,
			32'hAAAA_AAAA));
		queue_opening(make_request(ACT_INSERT, TRK_TRANSLATION, 32'hFFFF_FFFF,
			32'hFFFF_FFFF));
		queue_opening(make_request(ACT_INSERT, TRK_TRANSLATION, 32'h0, 32'h0));
		queue_opening(make_request(ACT_INSERT, TRK_TRANSLATION, 32'h0001_8000,
			32'h5555_5555));
		queue_opening(make_request(ACT_INSERT, TRK_TRANSLATION, 32'h0, 32'h1234_5678));
		queue_opening(make_request(ACT_FIND_NEXT, TRK_TRANSLATION, 32'h0, 32'h0));
		queue_opening(make_request(ACT_FIND_NEXT, TRK_TRANSLATION, 32'h0001_8001, 32'h0));
		queue_opening(make_request(ACT_FIND_NEXT, TRK_TRANSLATION, 32'hFFFF_FFFF, 32'h0));
		queue_opening(make_request(ACT_FIND_PREV, TRK_TRANSLATION, 32'h0, 32'h0));
		queue_opening(make_request(ACT_FIND_PREV, TRK_TRANSLATION, 32'h0001_8000, 32'h0));
		queue_opening(make_request(ACT_FIND_PREV, TRK_TRANSLATION, 32'hFFFF_FFFF, 32'h0));
		queue_opening(make_request(ACT_INSERT, TRK_ROTATION, 32'h0002_0000,
			32'hDEAD_BEEF));
		queue_opening(make_request(ACT_FIND_NEXT, TRK_ROTATION, 32'h0003_0000, 32'h0));
		queue_opening(make_request(ACT_FIND_PREV, TRK_ROTATION, 32'h0001_0000, 32'h0));
		queue_opening(make_request(ACT_INSERT, TRK_SCALING, 32'h7FFF_FFFF,
			32'h8000_0000));
		queue_opening(make_request(ACT_FIND_NEXT, TRK_SCALING, 32'h7FFF_FFFF, 32'h0));
		queue_opening(make_request(ACT_UNUSED, TRK_UNUSED, 32'hFFFF_FFFF,
			32'hFFFF_FFFF));
		foreach (opening_items[i]) begin
			send_request(opening_items[i]);
			items_sent++;
		end
		drain_results();

		// A quarter of the valid items are inserts, so the tracks fill over
		// the run and the later phases also meet full tracks.
		for (phase = 0; phase < 4; phase++) begin
			sender_idle    = idle_plan[phase];
			receiver_stall = stall_plan[phase];
			if (phase == 0)
				holds_asked++;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				send_request(random_request(25));
				items_sent++;
			end
			drain_results();
		end

		repeat (SETTLE_WAIT) @(posedge clk);
		if (sb.outstanding() != 0)
			sb.report($sformatf("%0d expected results never arrived", sb.outstanding()));

		$display("Covered %0d items in a directed opening and four handshake phases.",
			items_sent);
		$display("Results ok %0d, full %0d, not found %0d, empty %0d; track fill %0d/%0d/%0d.",
			sb.status_seen[ST_OK], sb.status_seen[ST_FULL], sb.status_seen[ST_NOT_FOUND],
			sb.status_seen[ST_EMPTY], sb.fill[0], sb.fill[1], sb.fill[2]);
		if (sb.mismatches == 0)
			$display("sorted_keyframe_table test passed");
		else
			$display("sorted_keyframe_table test failed");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/skt_pkg.sv
rtl/skt_ctrl.sv
rtl/skt_dp.sv
rtl/sorted_keyframe_table.sv
sim/sorted_keyframe_table_tb.sv
